// ===== hw/rtl/aik_pkg.sv =====
// Package for the arm inverse kinematics unit: widths, fixed-point constants,
// arctangent table and register indexes. No dependencies.
package aik_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ANG_FRAC      = 30;
    localparam int CORDIC_STEPS  = 30;

    localparam int COORD_W  = 19;
    localparam int LEN_W    = 18;
    localparam int ANGLE_W  = 20;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 104;

    // arctangent operand, working and angle widths
    localparam int TW = 50;
    localparam int NW = 52;
    localparam int CW = 44;
    localparam int ZW = 34;
    localparam int ATAN_LAT = 12 + CORDIC_STEPS;

    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
        30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
        30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
        30'd31,        30'd15,        30'd7,         30'd3,         30'd1
    };

    localparam logic [1:0] CFG_SHOULDER_H = 2'd0;
    localparam logic [1:0] CFG_UPPER_ARM  = 2'd1;
    localparam logic [1:0] CFG_FOREARM    = 2'd2;

    localparam logic [LEN_W-1:0] SHOULDER_H_RST = 18'd5308;
    localparam logic [LEN_W-1:0] UPPER_ARM_RST  = 18'd11796;
    localparam logic [LEN_W-1:0] FOREARM_RST    = 18'd11557;

    typedef struct packed {
        logic one;
        logic neg;
    } t_cls;

endpackage

// ===== hw/rtl/arm_inverse_kinematics_unit.sv =====
// Arm inverse kinematics unit, top level: squares, reach test, divider,
// square roots and four atan2 chains. Depends on aik_pkg, aik_delay, aik_div_cell, aik_sqrt_cell and aik_atan2.
//
//  channel   dir  word                                              handshake
//  s_axis    in   tdata: x, y, z                                    tvalid/tready
//  m_axis    out  tdata: base, shoulder, elbow, wrist_pitch, roll   tvalid/tready
//                 tuser: unreachable
//  cfg       in   index 0 shoulder height, 1 upper_arm, 2 forearm   wr_en
//
// One word per cycle unless the output buffer is full; the path to the output buffer
// runs through the 30-cell divider, the 31-cell square root and the 42-stage atan2 chains.
// Synchronous reset clears valids, the output buffer and the registers to defaults.
// A two-word output buffer takes results while m_axis stalls; when both are
// full the pipeline holds and s_axis tready is low.
module arm_inverse_kinematics_unit #(
    parameter int FRAC_BITS = aik_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // x [18:0], y [37:19], z [56:38]
    input  logic [aik_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // base [19:0], shoulder [39:20], elbow [59:40], wrist_pitch [79:60],
    // wrist_roll [99:80]
    output logic [aik_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    // unreachable [0]
    output logic                          o_m_axis_tuser,
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_index,
    input  logic [aik_pkg::LEN_W-1:0]     i_cfg_data
);
    import aik_pkg::*;

    localparam int RS        = ANG_FRAC - FRAC_BITS;
    localparam int SQ1_STEPS = 27;
    localparam int SQ2_STEPS = 31;
    localparam int DIV_STEPS = ANG_FRAC;
    localparam int T_ATAN    = 4 + DIV_STEPS + 3 + SQ2_STEPS + 1;
    localparam int D_XY      = T_ATAN - 1;
    localparam int D_RHI     = T_ATAN - (3 + SQ1_STEPS);
    localparam int D_C       = T_ATAN - (4 + DIV_STEPS + 1);
    localparam int D_K1      = T_ATAN - (4 + DIV_STEPS + 3);
    localparam int LAT       = T_ATAN + ATAN_LAT + 3;
    localparam int D_UNR     = LAT - 5;
    localparam int OW        = 5 * ANGLE_W + 1;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    function automatic logic [ANGLE_W-1:0] f_out_angle(input logic signed [36:0] a);
        logic signed [37:0] v;
        v = ($signed({a[36], a}) + (38'sd1 <<< (RS - 1))) >>> RS;
        if (v > 38'sd524287) begin
            return 20'h7FFFF;
        end else if (v < -38'sd524288) begin
            return 20'h80000;
        end
        return v[ANGLE_W-1:0];
    endfunction

    logic [LEN_W-1:0] r_base_h;
    logic [LEN_W-1:0] r_l1;
    logic [LEN_W-1:0] r_l2;

    logic            w_en;
    logic            w_acc;
    logic [LAT-1:0]  r_vld;

    logic signed [COORD_W-1:0] w_x;
    logic signed [COORD_W-1:0] w_y;
    logic signed [COORD_W-1:0] w_z;
    logic signed [37:0]        w_xx;
    logic signed [37:0]        w_yy;

    logic signed [COORD_W-1:0] r1_x;
    logic signed [COORD_W-1:0] r1_y;
    logic        [36:0]        r1_xx;
    logic        [36:0]        r1_yy;
    logic signed [20:0]        r1_za;
    logic        [35:0]        r1_l1sq;
    logic        [35:0]        r1_l2sq;
    logic        [36:0]        r1_den;

    logic signed [41:0]        w_zaz;
    logic        [37:0]        r2_rr;
    logic        [38:0]        r2_zaz;
    logic        [36:0]        r2_lsum;
    logic        [36:0]        r2_den;

    logic signed [40:0]        r3_num;
    logic        [37:0]        r3_rr;
    logic        [36:0]        r3_den;

    logic        [40:0]        w_nmag;
    logic                      w_big;
    logic                      w_full;
    logic                      w_den0;
    t_cls                      r4_cls;
    logic                      r4_unr;

    logic [37:0] d_rem [DIV_STEPS+1];
    logic [36:0] d_d   [DIV_STEPS+1];
    logic [29:0] d_q   [DIV_STEPS+1];

    t_cls                      w_cls_d;
    logic signed [31:0]        w_q;
    logic signed [31:0]        r35_c;
    logic signed [63:0]        w_cc;
    logic signed [50:0]        w_lc;
    logic        [60:0]        r36_cc;
    logic signed [50:0]        r36_lc;
    logic        [60:0]        r37_v;
    logic signed [TW-1:0]      r37_k1;

    logic [53:0] s1_v   [SQ1_STEPS+1];
    logic [53:0] s1_res [SQ1_STEPS+1];
    logic [60:0] s2_v   [SQ2_STEPS+1];
    logic [60:0] s2_res [SQ2_STEPS+1];

    logic        [48:0]        w_k2;
    logic signed [TW-1:0]      r69_k2;
    logic        [30:0]        r69_s;
    logic signed [COORD_W-1:0] w_x_d;
    logic signed [COORD_W-1:0] w_y_d;
    logic signed [20:0]        w_za_d;
    logic        [26:0]        w_rhi_d;
    logic signed [31:0]        w_c_d;
    logic signed [TW-1:0]      w_k1_d;
    logic                      w_unr_d;

    logic signed [ZW-1:0]      w_a_base;
    logic signed [ZW-1:0]      w_a_elbow;
    logic signed [ZW-1:0]      w_a_reach;
    logic signed [ZW-1:0]      w_a_link;

    logic signed [ZW-1:0]      r112_base;
    logic signed [ZW-1:0]      r112_t2;
    logic signed [ZW:0]        r112_t1;
    logic signed [36:0]        r113_e0;
    logic signed [36:0]        r113_e1;
    logic signed [36:0]        r113_e2;
    logic signed [36:0]        r113_e3;
    logic [OW-1:0]             r114_res;

    logic          r_ov0;
    logic          r_ov1;
    logic [OW-1:0] r_d0;
    logic [OW-1:0] r_d1;
    logic          w_pop;
    logic          w_push;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_h <= SHOULDER_H_RST;
            r_l1     <= UPPER_ARM_RST;
            r_l2     <= FOREARM_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SHOULDER_H: r_base_h <= i_cfg_data;
                CFG_UPPER_ARM:  r_l1     <= i_cfg_data;
                CFG_FOREARM:    r_l2     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en  = !r_ov1;
    assign w_acc = i_s_axis_tvalid && w_en;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    // squares and reach terms
    assign w_x  = $signed(i_s_axis_tdata[18:0]);
    assign w_y  = $signed(i_s_axis_tdata[37:19]);
    assign w_z  = $signed(i_s_axis_tdata[56:38]);
    assign w_xx = w_x * w_x;
    assign w_yy = w_y * w_y;
    assign w_zaz = r1_za * r1_za;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x    <= w_x;
            r1_y    <= w_y;
            r1_xx   <= w_xx[36:0];
            r1_yy   <= w_yy[36:0];
            r1_za   <= {{2{w_z[COORD_W-1]}}, w_z} - $signed({3'b0, r_base_h});
            r1_l1sq <= r_l1 * r_l1;
            r1_l2sq <= r_l2 * r_l2;
            r1_den  <= {36'(r_l1 * r_l2), 1'b0};

            r2_rr   <= {1'b0, r1_xx} + {1'b0, r1_yy};
            r2_zaz  <= w_zaz[38:0];
            r2_lsum <= {1'b0, r1_l1sq} + {1'b0, r1_l2sq};
            r2_den  <= r1_den;

            r3_num  <= $signed({3'b0, r2_rr}) + $signed({2'b0, r2_zaz})
                     - $signed({4'b0, r2_lsum});
            r3_rr   <= r2_rr;
            r3_den  <= r2_den;
        end
    end

    // clamp test
    assign w_nmag = r3_num[40] ? 41'(-r3_num) : 41'(r3_num);
    assign w_den0 = (r3_den == '0);
    assign w_big  = w_nmag >  {4'b0, r3_den};
    assign w_full = w_nmag >= {4'b0, r3_den};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_cls.one <= w_den0 || w_full;
            r4_cls.neg <= r3_num[40];
            r4_unr     <= w_den0 || w_big;
            d_rem[0]   <= {1'b0, w_nmag[36:0]};
            d_d[0]     <= r3_den;
            d_q[0]     <= '0;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        aik_div_cell u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (d_rem[k]),
            .i_d   (d_d[k]),
            .i_q   (d_q[k]),
            .o_rem (d_rem[k+1]),
            .o_d   (d_d[k+1]),
            .o_q   (d_q[k+1])
        );
    end

    aik_delay #(.W($bits(t_cls)), .N(DIV_STEPS)) u_dly_cls (
        .i_clk (i_clk), .i_en (w_en), .i_d (r4_cls), .o_q (w_cls_d)
    );
    aik_delay #(.W(1), .N(D_UNR)) u_dly_unr (
        .i_clk (i_clk), .i_en (w_en), .i_d (r4_unr), .o_q (w_unr_d)
    );

    // cosine, sine argument and link vector
    assign w_q  = $signed({2'b0, d_q[DIV_STEPS]});
    assign w_cc = r35_c * r35_c;
    assign w_lc = $signed({1'b0, r_l2}) * r35_c;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_cls_d.one) begin
                r35_c <= w_cls_d.neg ? -ONE_Q30 : ONE_Q30;
            end else begin
                r35_c <= w_cls_d.neg ? -w_q : w_q;
            end
            r36_cc <= w_cc[60:0];
            r36_lc <= w_lc;
            r37_v  <= (61'(1) << 60) - r36_cc;
            r37_k1 <= $signed({2'b0, r_l1, 30'b0}) + r36_lc[TW-1:0];
        end
    end

    // horizontal radius, 8 extra fraction bits
    assign s1_v[0]   = {r3_rr, 16'b0};
    assign s1_res[0] = '0;
    for (genvar k = 0; k < SQ1_STEPS; k++) begin : g_sq1
        aik_sqrt_cell #(.W(54), .B(2 * (SQ1_STEPS - 1 - k))) u_sq (
            .i_clk (i_clk), .i_en (w_en),
            .i_v   (s1_v[k]),   .i_res (s1_res[k]),
            .o_v   (s1_v[k+1]), .o_res (s1_res[k+1])
        );
    end

    assign s2_v[0]   = r37_v;
    assign s2_res[0] = '0;
    for (genvar k = 0; k < SQ2_STEPS; k++) begin : g_sq2
        aik_sqrt_cell #(.W(61), .B(2 * (SQ2_STEPS - 1 - k))) u_sq (
            .i_clk (i_clk), .i_en (w_en),
            .i_v   (s2_v[k]),   .i_res (s2_res[k]),
            .o_v   (s2_v[k+1]), .o_res (s2_res[k+1])
        );
    end

    assign w_k2 = r_l2 * s2_res[SQ2_STEPS][30:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r69_k2 <= $signed({1'b0, w_k2});
            r69_s  <= s2_res[SQ2_STEPS][30:0];
        end
    end

    aik_delay #(.W(COORD_W), .N(D_XY)) u_dly_x (
        .i_clk (i_clk), .i_en (w_en), .i_d (r1_x), .o_q (w_x_d)
    );
    aik_delay #(.W(COORD_W), .N(D_XY)) u_dly_y (
        .i_clk (i_clk), .i_en (w_en), .i_d (r1_y), .o_q (w_y_d)
    );
    aik_delay #(.W(21), .N(D_XY)) u_dly_za (
        .i_clk (i_clk), .i_en (w_en), .i_d (r1_za), .o_q (w_za_d)
    );
    aik_delay #(.W(27), .N(D_RHI)) u_dly_rhi (
        .i_clk (i_clk), .i_en (w_en), .i_d (s1_res[SQ1_STEPS][26:0]), .o_q (w_rhi_d)
    );
    aik_delay #(.W(32), .N(D_C)) u_dly_c (
        .i_clk (i_clk), .i_en (w_en), .i_d (r35_c), .o_q (w_c_d)
    );
    aik_delay #(.W(TW), .N(D_K1)) u_dly_k1 (
        .i_clk (i_clk), .i_en (w_en), .i_d (r37_k1), .o_q (w_k1_d)
    );

    aik_atan2 u_atan_base (
        .i_clk (i_clk), .i_en (w_en),
        .i_y   ({{(TW-COORD_W){w_y_d[COORD_W-1]}}, w_y_d}),
        .i_x   ({{(TW-COORD_W){w_x_d[COORD_W-1]}}, w_x_d}),
        .o_z   (w_a_base)
    );
    aik_atan2 u_atan_elbow (
        .i_clk (i_clk), .i_en (w_en),
        .i_y   ({{(TW-31){1'b0}}, r69_s}),
        .i_x   ({{(TW-32){w_c_d[31]}}, w_c_d}),
        .o_z   (w_a_elbow)
    );
    aik_atan2 u_atan_reach (
        .i_clk (i_clk), .i_en (w_en),
        .i_y   ({{(TW-29){w_za_d[20]}}, w_za_d, 8'b0}),
        .i_x   ({{(TW-27){1'b0}}, w_rhi_d}),
        .o_z   (w_a_reach)
    );
    aik_atan2 u_atan_link (
        .i_clk (i_clk), .i_en (w_en),
        .i_y   (r69_k2),
        .i_x   (w_k1_d),
        .o_z   (w_a_link)
    );

    // joint angles
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r112_base <= w_a_base;
            r112_t2   <= w_a_elbow;
            r112_t1   <= {w_a_reach[ZW-1], w_a_reach} - {w_a_link[ZW-1], w_a_link};

            r113_e0 <= 37'(r112_base);
            r113_e2 <= 37'(r112_t2);
            r113_e1 <= 37'(r112_t1) - 37'(HALF_PI_Q30);
            r113_e3 <= -37'(r112_t1) - 37'(r112_t2) - 37'(HALF_PI_Q30);

            r114_res <= {w_unr_d, f_out_angle(r113_e0), f_out_angle(r113_e3),
                         f_out_angle(r113_e2), f_out_angle(r113_e1),
                         f_out_angle(r113_e0)};
        end
    end

    // two-word output buffer
    assign w_pop  = r_ov0 && i_m_axis_tready;
    assign w_push = w_en && r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov0 <= 1'b0;
            r_ov1 <= 1'b0;
        end else if (r_ov1) begin
            if (w_pop) begin
                r_ov1 <= 1'b0;
            end
        end else if (!r_ov0 || w_pop) begin
            r_ov0 <= w_push;
        end else if (w_push) begin
            r_ov1 <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ov1) begin
            if (w_pop) begin
                r_d0 <= r_d1;
            end
        end else if (!r_ov0 || w_pop) begin
            r_d0 <= r114_res;
        end else begin
            r_d1 <= r114_res;
        end
    end

    assign o_m_axis_tvalid = r_ov0;
    assign o_m_axis_tdata  = {{(M_DATA_W-5*ANGLE_W){1'b0}}, r_d0[5*ANGLE_W-1:0]};
    assign o_m_axis_tuser  = r_d0[OW-1];
endmodule

// ===== hw/rtl/aik_delay.sv =====
// Shift line of N stages with a common advance enable.
// Depends on nothing.
module aik_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[N-1];
endmodule

// ===== hw/rtl/aik_sqrt_cell.sv =====
// One digit step of a pipelined floor square root.
// Depends on nothing.
module aik_sqrt_cell #(
    parameter int W = 61,
    parameter int B = 0
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_v,
    input  logic [W-1:0] i_res,
    output logic [W-1:0] o_v,
    output logic [W-1:0] o_res
);
    localparam logic [W-1:0] BIT = W'(1) << B;

    logic [W-1:0] w_t;
    logic [W-1:0] r_v;
    logic [W-1:0] r_res;

    assign w_t = i_res + BIT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_v >= w_t) begin
                r_v   <= i_v - w_t;
                r_res <= (i_res >> 1) + BIT;
            end else begin
                r_v   <= i_v;
                r_res <= i_res >> 1;
            end
        end
    end

    assign o_v   = r_v;
    assign o_res = r_res;
endmodule

// ===== hw/rtl/aik_div_cell.sv =====
// One restoring step of the pipelined fraction divider.
// Depends on nothing.
module aik_div_cell (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [37:0] i_rem,
    input  logic [36:0] i_d,
    input  logic [29:0] i_q,
    output logic [37:0] o_rem,
    output logic [36:0] o_d,
    output logic [29:0] o_q
);
    logic [37:0] w_r2;
    logic [37:0] r_rem;
    logic [36:0] r_d;
    logic [29:0] r_q;

    assign w_r2 = {i_rem[36:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= i_d;
            if (w_r2 >= {1'b0, i_d}) begin
                r_rem <= w_r2 - {1'b0, i_d};
                r_q   <= {i_q[28:0], 1'b1};
            end else begin
                r_rem <= w_r2;
                r_q   <= {i_q[28:0], 1'b0};
            end
        end
    end

    assign o_rem = r_rem;
    assign o_d   = r_d;
    assign o_q   = r_q;
endmodule

// ===== hw/rtl/aik_cordic_cell.sv =====
// One CORDIC vectoring step; angle table from aik_pkg.
// Depends on aik_pkg.
module aik_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [aik_pkg::CW-1:0]   i_x,
    input  logic signed [aik_pkg::CW-1:0]   i_y,
    input  logic signed [aik_pkg::ZW-1:0]   i_z,
    input  logic                            i_zero,
    output logic signed [aik_pkg::CW-1:0]   o_x,
    output logic signed [aik_pkg::CW-1:0]   o_y,
    output logic signed [aik_pkg::ZW-1:0]   o_z,
    output logic                            o_zero
);
    import aik_pkg::*;

    localparam logic signed [ZW-1:0] ANG = $signed({4'b0, ATAN_TAB[STEP]});

    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_zero;

    assign w_xs = i_x >>> STEP;
    assign w_ys = i_y >>> STEP;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero <= i_zero;
            if (!i_y[CW-1]) begin
                r_x <= i_x + w_ys;
                r_y <= i_y - w_xs;
                r_z <= i_z + ANG;
            end else begin
                r_x <= i_x - w_ys;
                r_y <= i_y + w_xs;
                r_z <= i_z - ANG;
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_zero = r_zero;
endmodule

// ===== hw/rtl/aik_atan2.sv =====
// Pipelined atan2 in Q30: magnitude, binary normalizing shifts, quadrant fold
// and a chain of CORDIC cells. Depends on aik_pkg, aik_cordic_cell.
module aik_atan2 (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [aik_pkg::TW-1:0]   i_y,
    input  logic signed [aik_pkg::TW-1:0]   i_x,
    output logic signed [aik_pkg::ZW-1:0]   o_z
);
    import aik_pkg::*;

    localparam int NS = 11;

    logic        [TW-1:0] w_ax;
    logic        [TW-1:0] w_ay;
    logic signed [NW-1:0] r_nx [NS];
    logic signed [NW-1:0] r_ny [NS];
    logic        [NW-1:0] r_nm [NS];
    logic signed [NW-1:0] w_fx;
    logic signed [NW-1:0] w_fy;
    logic signed [CW-1:0] c_x [CORDIC_STEPS+1];
    logic signed [CW-1:0] c_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0] c_z [CORDIC_STEPS+1];
    logic                 c_zero [CORDIC_STEPS+1];

    assign w_ax = i_x[TW-1] ? TW'(-i_x) : TW'(i_x);
    assign w_ay = i_y[TW-1] ? TW'(-i_y) : TW'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx[0] <= {{(NW-TW){i_x[TW-1]}}, i_x};
            r_ny[0] <= {{(NW-TW){i_y[TW-1]}}, i_y};
            r_nm[0] <= {{(NW-TW){1'b0}}, (w_ax > w_ay) ? w_ax : w_ay};
        end
    end

    // down to below 2^40
    for (genvar j = 0; j < 4; j++) begin : g_right
        localparam int K = 8 >> j;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_nm[j] >= (NW'(1) << (39 + K))) begin
                    r_nx[j+1] <= r_nx[j] >>> K;
                    r_ny[j+1] <= r_ny[j] >>> K;
                    r_nm[j+1] <= r_nm[j] >> K;
                end else begin
                    r_nx[j+1] <= r_nx[j];
                    r_ny[j+1] <= r_ny[j];
                    r_nm[j+1] <= r_nm[j];
                end
            end
        end
    end

    // up to at least 2^39
    for (genvar j = 0; j < 6; j++) begin : g_left
        localparam int K = 32 >> j;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_nm[4+j] < (NW'(1) << (40 - K))) begin
                    r_nx[5+j] <= r_nx[4+j] <<< K;
                    r_ny[5+j] <= r_ny[4+j] <<< K;
                    r_nm[5+j] <= r_nm[4+j] << K;
                end else begin
                    r_nx[5+j] <= r_nx[4+j];
                    r_ny[5+j] <= r_ny[4+j];
                    r_nm[5+j] <= r_nm[4+j];
                end
            end
        end
    end

    assign w_fx = r_nx[NS-1][NW-1] ? -r_nx[NS-1] : r_nx[NS-1];
    assign w_fy = r_nx[NS-1][NW-1] ? -r_ny[NS-1] : r_ny[NS-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            c_x[0]    <= w_fx[CW-1:0];
            c_y[0]    <= w_fy[CW-1:0];
            c_zero[0] <= (r_nm[NS-1] == '0);
            if (r_nx[NS-1][NW-1]) begin
                c_z[0] <= r_ny[NS-1][NW-1] ? -PI_Q30 : PI_Q30;
            end else begin
                c_z[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        aik_cordic_cell #(.STEP(k)) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_x    (c_x[k]),
            .i_y    (c_y[k]),
            .i_z    (c_z[k]),
            .i_zero (c_zero[k]),
            .o_x    (c_x[k+1]),
            .o_y    (c_y[k+1]),
            .o_z    (c_z[k+1]),
            .o_zero (c_zero[k+1])
        );
    end

    assign o_z = c_zero[CORDIC_STEPS] ? '0 : c_z[CORDIC_STEPS];
endmodule

// ===== hw/rtl/aik_checker.sv =====
// Port-level checks for the arm inverse kinematics unit, bound to the top.
// Depends on aik_pkg and arm_inverse_kinematics_unit.
module aik_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [aik_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    input logic                          o_m_axis_tuser
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata)
            && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("buffer not empty after reset");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input held off with no result waiting");

    a_roll_is_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[19:0] == o_m_axis_tdata[99:80])
        else $error("wrist roll differs from base yaw");
endmodule

bind arm_inverse_kinematics_unit aik_checker u_aik_checker (.*);

// ===== tb/sv/tb_arm_inverse_kinematics_unit.sv =====
// Testbench for arm_inverse_kinematics_unit: streams target words, predicts the joint
// angles with a fixed-point model of the solver and checks every result word.
// Depends on aik_pkg and the arm_inverse_kinematics_unit RTL.
module tb_arm_inverse_kinematics_unit;
    import aik_pkg::*;

    typedef struct packed {
        logic [ANGLE_W-1:0] base;
        logic [ANGLE_W-1:0] shoulder;
        logic [ANGLE_W-1:0] elbow;
        logic [ANGLE_W-1:0] wrist_pitch;
        logic [ANGLE_W-1:0] wrist_roll;
        logic               unreachable;
    } t_angles;

    localparam longint ONE_Q30 = 64'sd1 << ANG_FRAC;
    localparam longint ANG_MAX = 524287;
    localparam longint ANG_MIN = -524288;
    localparam int     LIMIT   = 2000000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic i_clk = 0, i_rst_n = 0;
    logic i_s_axis_tvalid = 0, i_m_axis_tready = 0;
    logic [S_DATA_W-1:0] i_s_axis_tdata = '0;
    logic o_s_axis_tready, o_m_axis_tvalid, o_m_axis_tuser;
    logic [M_DATA_W-1:0] o_m_axis_tdata;
    logic i_cfg_wr_en = 0;
    logic [1:0] i_cfg_index = CFG_SHOULDER_H;
    logic [LEN_W-1:0] i_cfg_data = '0;

    arm_inverse_kinematics_unit DUT (.*);

    logic [LEN_W-1:0] height_q, upper_q, fore_q;
    logic [S_DATA_W-1:0] target_q[$];
    t_angles angles_q[$];
    int errors = 0, cycles = 0;
    int gap = 0, stall = 0, hold_off = 0;
    bit feeding = 0;
    bit in_acc = 0, out_acc = 0;

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // handshakes as seen at the accepting edge
    always @(posedge i_clk) begin
        in_acc  <= i_s_axis_tvalid && o_s_axis_tready;
        out_acc <= o_m_axis_tvalid && i_m_axis_tready;
    end

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint iroot(longint unsigned v);
        longint unsigned res = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vec_angle(longint y, longint x);
        longint unsigned m;
        longint z = 0, xs, ys;
        m = (x < 0 ? -x : x) > (y < 0 ? -y : y) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
        if (m == 0) return 0;
        while (m >= (64'd1 << 40)) begin
            x = shr(x, 1); y = shr(y, 1); m >>= 1;
        end
        while (m < (64'd1 << 39)) begin
            x *= 2; y *= 2; m <<= 1;
        end
        if (x < 0) begin
            z = (y < 0) ? -longint'(PI_Q30) : longint'(PI_Q30);
            x = -x; y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = shr(x, i); ys = shr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
            end else begin
                x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic longint ratio_q30(longint n, longint d);
        longint q = 0, rem = n;
        if (n >= d) return ONE_Q30;
        for (int i = 0; i < ANG_FRAC; i++) begin
            rem <<= 1; q <<= 1;
            if (rem >= d) begin
                rem -= d; q |= 1;
            end
        end
        return q;
    endfunction

    function automatic logic [ANGLE_W-1:0] to_out(longint a);
        longint v = shr(a + (64'sd1 << (ANG_FRAC - FRAC_BITS_DEF - 1)), ANG_FRAC - FRAC_BITS_DEF);
        if (v > ANG_MAX) v = ANG_MAX;
        if (v < ANG_MIN) v = ANG_MIN;
        return v[ANGLE_W-1:0];
    endfunction

    function automatic t_angles solve_joints(logic [S_DATA_W-1:0] w);
        t_angles r;
        longint x, y, z, l1, l2, za, rr, rh, num, den, c, s, base, t1, t2;
        x = longint'(signed'(w[18:0]));
        y = longint'(signed'(w[37:19]));
        z = longint'(signed'(w[56:38]));
        l1 = upper_q; l2 = fore_q;
        za = z - longint'(height_q);
        rr = x * x + y * y;
        rh = iroot(rr << 16);
        num = rr + za * za - l1 * l1 - l2 * l2;
        den = 2 * l1 * l2;
        r.unreachable = 1;
        if (den == 0) c = (num < 0) ? -ONE_Q30 : ONE_Q30;
        else if (num > den) c = ONE_Q30;
        else if (num < -den) c = -ONE_Q30;
        else begin
            r.unreachable = 0;
            c = (num < 0) ? -ratio_q30(-num, den) : ratio_q30(num, den);
        end
        s = iroot((64'd1 << 60) - c * c);
        base = vec_angle(y, x);
        t2 = vec_angle(s, c);
        t1 = vec_angle(za * 256, rh) - vec_angle(l2 * s, l1 * ONE_Q30 + l2 * c);
        r.base = to_out(base);
        r.shoulder = to_out(t1 - HALF_PI_Q30);
        r.elbow = to_out(t2);
        r.wrist_pitch = to_out(-t1 - t2 - HALF_PI_Q30);
        r.wrist_roll = to_out(base);
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (in_acc) begin
            angles_q.push_back(solve_joints(i_s_axis_tdata));
            target_q.pop_front();
            gap = $urandom_range(3) == 0 ? 0 : $urandom_range(19);
            if ($urandom_range(4) == 0) gap = 0;
        end else if (!i_s_axis_tvalid && gap > 0) gap = gap - 1;
        if (feeding && target_q.size() > 0 && (gap == 0 || (i_s_axis_tvalid && !in_acc))) begin
            i_s_axis_tvalid <= 1;
            i_s_axis_tdata <= target_q[0];
        end else i_s_axis_tvalid <= 0;
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off = hold_off - 1;
            i_m_axis_tready <= 0;
        end else if (out_acc || stall == 0) begin
            stall = $urandom_range(2) == 0 ? 0 : $urandom_range(19);
            i_m_axis_tready <= (stall == 0);
        end else begin
            stall = stall - 1;
            i_m_axis_tready <= (stall == 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_angles got, exp;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[19:0], o_m_axis_tdata[39:20], o_m_axis_tdata[59:40],
                   o_m_axis_tdata[79:60], o_m_axis_tdata[99:80], o_m_axis_tuser};
            if (angles_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                exp = angles_q.pop_front();
                if (got.base !== exp.base) begin
                    $error("base_angle exp %h got %h", exp.base, got.base); errors++;
                end
                if (got.shoulder !== exp.shoulder) begin
                    $error("shoulder_angle exp %h got %h", exp.shoulder, got.shoulder);
                    errors++;
                end
                if (got.elbow !== exp.elbow) begin
                    $error("elbow_angle exp %h got %h", exp.elbow, got.elbow); errors++;
                end
                if (got.wrist_pitch !== exp.wrist_pitch) begin
                    $error("wrist_pitch_angle exp %h got %h", exp.wrist_pitch,
                           got.wrist_pitch);
                    errors++;
                end
                if (got.wrist_roll !== exp.wrist_roll) begin
                    $error("wrist_roll_angle exp %h got %h", exp.wrist_roll, got.wrist_roll);
                    errors++;
                end
                if (got.unreachable !== exp.unreachable) begin
                    $error("unreachable exp %b got %b", exp.unreachable, got.unreachable);
                    errors++;
                end
            end
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_target(int x, int y, int z);
        logic [S_DATA_W-1:0] w = '0;
        w[18:0] = x[18:0]; w[37:19] = y[18:0]; w[56:38] = z[18:0];
        return w;
    endfunction

    // reachable-ish point near the arm's envelope, or a wide random one
    function automatic logic [S_DATA_W-1:0] random_target();
        int reach, x, y, z;
        if ($urandom_range(9) < 7) begin
            reach = int'(upper_q) + int'(fore_q) + 2;
            if (reach > 262143) reach = 262143;
            x = $urandom_range(2 * reach) - reach;
            y = $urandom_range(2 * reach) - reach;
            z = $urandom_range(2 * reach) - reach + int'(height_q);
            if (z > 262143) z = 262143;
            return pack_target(x, y, z);
        end
        return {7'($urandom), 57'({$urandom, $urandom})};
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [LEN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 0;
        if (idx == CFG_SHOULDER_H) height_q = val;
        else if (idx == CFG_UPPER_ARM) upper_q = val;
        else if (idx == CFG_FOREARM) fore_q = val;
    endtask

    task automatic drain();
        feeding = 0;
        while (target_q.size() > 0) begin
            feeding = 1;
            @(negedge i_clk);
        end
        feeding = 0;
        while (angles_q.size() > 0) @(negedge i_clk);
        repeat (130) @(negedge i_clk);
    endtask

    task automatic run_phase(int n);
        for (int i = 0; i < n; i++) target_q.push_back(random_target());
        feeding = 1;
        drain();
    endtask

    initial begin
        height_q = SHOULDER_H_RST; upper_q = UPPER_ARM_RST; fore_q = FOREARM_RST;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;
        // directed
        target_q.push_back(pack_target(0, 0, 0));
        target_q.push_back(pack_target(0, 0, 5308));
        target_q.push_back(pack_target(262143, 262143, 262143));
        target_q.push_back(pack_target(-262144, -262144, -262144));
        target_q.push_back(pack_target(-262144, 0, 0));
        target_q.push_back(pack_target(-1000, -1, 5308));
        target_q.push_back(pack_target(-1000, 0, 5308));
        target_q.push_back(pack_target(0, 262143, -262144));
        target_q.push_back(pack_target(23353, 0, 5308));
        target_q.push_back(pack_target(239, 0, 5308));
        target_q.push_back(pack_target(239, 0, 5308 + 1));
        target_q.push_back(pack_target(23354, 0, 5308));
        target_q.push_back(pack_target(12000, -9000, 9000));
        target_q.push_back(pack_target(100, 200, 300) | {7'h7f, 57'd0});
        feeding = 1;
        drain();
        write_reg(CFG_UPPER_ARM, '0);
        target_q.push_back(pack_target(1000, 1000, 1000));
        target_q.push_back(pack_target(0, 0, 5308));
        feeding = 1;
        drain();
        write_reg(CFG_SHOULDER_H, 18'd262143);
        write_reg(CFG_UPPER_ARM, 18'd262143);
        write_reg(CFG_FOREARM, 18'd262143);
        write_reg(CFG_UNUSED, 18'h155);
        run_phase(250);
        write_reg(CFG_SHOULDER_H, '0);
        write_reg(CFG_UPPER_ARM, 18'd1);
        write_reg(CFG_FOREARM, 18'd1);
        run_phase(150);
        write_reg(CFG_FOREARM, '0);
        run_phase(50);
        write_reg(CFG_SHOULDER_H, SHOULDER_H_RST);
        write_reg(CFG_UPPER_ARM, UPPER_ARM_RST);
        write_reg(CFG_FOREARM, FOREARM_RST);
        // long receiver hold-off while the sender keeps streaming
        for (int i = 0; i < 300; i++) target_q.push_back(random_target());
        hold_off = 600;
        feeding = 1;
        drain();
        for (int k = 0; k < 4; k++) begin
            write_reg(CFG_SHOULDER_H, 18'($urandom));
            write_reg(CFG_UPPER_ARM, 18'($urandom_range(30000, 1)));
            write_reg(CFG_FOREARM, 18'($urandom_range(30000, 1)));
            run_phase(240);
        end
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
